FILE: hdl/stts_pkg.sv
// shared types and constants for the sorted time table seek block
// no dependencies; imported by stts_ctrl, stts_dp and sorted_time_table_seek_top
package stts_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int NUM_W           = 10;

  // command codes; bit 1 selects a seek, so code three seeks as well
  localparam logic [1:0] CMD_CLEAR     = 2'd0;
  localparam logic [1:0] CMD_APPEND    = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;
  localparam logic [1:0] CMD_QUERY_ALT = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_STORED  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_ORDER   = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [62:0]        entry_time;
    logic [63:0]        entry_offset;
    logic signed [63:0] query_time;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [NUM_W-1:0] chunk_number;
    logic [63:0]      chunk_offset;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic start;     // input word accepted
    logic step;      // one search probe
    logic finish;    // search closed, pick the index
    logic load_out;  // move the result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_search;
    logic need_fetch;
    logic search_done;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hdl/sorted_time_table_seek_top.sv
// top level of the sorted time table seek block: controller plus datapath
// depends on stts_pkg, stts_ctrl, stts_dp
//
//   channel | ports                        | word type
//   input   | in_valid, in_ready, in_word  | stts_pkg::in_word_t
//   result  | out_valid, out_ready, out_word | stts_pkg::out_word_t
//
// one word in flight; clear and append pass through the accept step and then the result load
// a seek runs one probe of the time memory per cycle until the search bounds meet,
// then the offset memory read and the result load
// a result waits in the output register while the next word is accepted
// a new result finds the output register still full: the controller holds until out_ready
// reset is synchronous; the memories need no clearing, entry count starts at zero
module sorted_time_table_seek_top #(
  parameter int TABLE_DEPTH = stts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stts_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output stts_pkg::out_word_t out_word
);
  import stts_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  stts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .dp_stat  (dp_stat),
    .ctrl_cmd (ctrl_cmd)
  );

  stts_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .ctrl_cmd  (ctrl_cmd),
    .dp_stat   (dp_stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // one word at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while another is in flight");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl_cmd.start, ctrl_cmd.step, ctrl_cmd.finish, ctrl_cmd.load_out}))
    else $error("controller issued more than one command");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_non_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != ST_OK) |->
      (out_word.chunk_number == '0) && (out_word.chunk_offset == '0))
    else $error("non-seek result carries chunk data");

endmodule

FILE: hdl/stts_ctrl.sv
// controller state machine for the seek table: sequences accept, search, fetch, respond
// depends on stts_pkg
module stts_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  stts_pkg::dp_stat_t   dp_stat,
  output stts_pkg::ctrl_cmd_t  ctrl_cmd
);
  import stts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_FETCH  = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctrl_cmd  = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl_cmd.start = 1'b1;
          if (dp_stat.need_search) state_nxt = S_SEARCH;
          else if (dp_stat.need_fetch) state_nxt = S_FETCH;
          else state_nxt = S_RESP;
        end
      end
      S_SEARCH: begin
        if (dp_stat.search_done) begin
          ctrl_cmd.finish = 1'b1;
          state_nxt = S_FETCH;
        end else begin
          ctrl_cmd.step = 1'b1;
        end
      end
      S_FETCH: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (dp_stat.out_free) begin
          ctrl_cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/stts_dp.sv
// datapath for the seek table: time and offset memories, search bounds, output register
// depends on stts_pkg; driven by stts_ctrl through ctrl_cmd_t
module stts_dp #(
  parameter int TABLE_DEPTH = stts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stts_pkg::in_word_t   in_word,
  input  stts_pkg::ctrl_cmd_t  ctrl_cmd,
  output stts_pkg::dp_stat_t   dp_stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output stts_pkg::out_word_t  out_word
);
  import stts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [62:0] time_mem [TABLE_DEPTH];
  logic [63:0] off_mem  [TABLE_DEPTH];

  logic [CW-1:0] count_r, count_nxt;
  logic [62:0]   last_r, last_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic          eq_r, eq_nxt;
  logic [62:0]   q_r, q_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [2:0]    res_status_r, res_status_nxt;
  logic [62:0]   rd_time_r;
  logic [63:0]   rd_off_r;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_r, out_nxt;

  logic          is_clear, is_append, is_query;
  logic          empty, full, order_bad, q_neg, wr_en;
  logic          probe_lt, probe_eq;
  logic [CW-1:0] sel;
  logic [NUM_W+AW-1:0] idx_ext;

  always_comb begin
    is_clear  = 1'b0;
    is_append = 1'b0;
    is_query  = 1'b0;
    unique case (in_word.cmd) inside
      CMD_CLEAR:                is_clear  = 1'b1;
      CMD_APPEND:               is_append = 1'b1;
      CMD_QUERY, CMD_QUERY_ALT: is_query  = 1'b1;
      default:                  is_query  = 1'b1;
    endcase
  end

  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(TABLE_DEPTH));
  assign order_bad = !empty && (in_word.entry_time < last_r);
  assign q_neg     = in_word.query_time[63];
  assign wr_en     = ctrl_cmd.start && is_append && !full && !order_bad;

  assign dp_stat.need_search = is_query && !empty && !q_neg;
  assign dp_stat.need_fetch  = is_query && !empty && q_neg;
  assign dp_stat.search_done = (lo_r == hi_r);
  assign dp_stat.out_free    = !out_valid_r || out_ready;

  // rd_time_r holds the entry at mid_r
  assign probe_lt = (rd_time_r < q_r);
  assign probe_eq = (rd_time_r == q_r);

  // lower bound lands on the first entry >= query; back off by one unless it matched or is entry zero
  always_comb begin
    if (lo_r == count_r) sel = count_r - CW'(1);
    else if (eq_r) sel = lo_r;
    else if (lo_r == '0) sel = '0;
    else sel = lo_r - CW'(1);
  end

  always_comb begin
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    eq_nxt         = eq_r;
    q_nxt          = q_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    if (ctrl_cmd.start) begin
      lo_nxt = '0;
      hi_nxt = count_r;
      eq_nxt = 1'b0;
      q_nxt  = in_word.query_time[62:0];
      idx_nxt = '0;
      if (is_clear) begin
        count_nxt      = '0;
        last_nxt       = '0;
        res_status_nxt = ST_CLEARED;
      end else if (is_append) begin
        if (full) begin
          res_status_nxt = ST_FULL;
        end else if (order_bad) begin
          res_status_nxt = ST_ORDER;
        end else begin
          count_nxt      = count_r + CW'(1);
          last_nxt       = in_word.entry_time;
          res_status_nxt = ST_STORED;
        end
      end else begin
        res_status_nxt = empty ? ST_EMPTY : ST_OK;
      end
    end else if (ctrl_cmd.step) begin
      if (probe_lt) begin
        lo_nxt = mid_r + CW'(1);
      end else begin
        hi_nxt = mid_r;
        eq_nxt = probe_eq;
      end
    end else if (ctrl_cmd.finish) begin
      idx_nxt = sel[AW-1:0];
    end
    mid_nxt = lo_nxt + ((hi_nxt - lo_nxt) >> 1);
  end

  assign idx_ext = {{NUM_W{1'b0}}, idx_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (ctrl_cmd.load_out) begin
      out_valid_nxt        = 1'b1;
      out_nxt.status       = res_status_r;
      out_nxt.chunk_number = (res_status_r == ST_OK) ? idx_ext[NUM_W-1:0] : '0;
      out_nxt.chunk_offset = (res_status_r == ST_OK) ? rd_off_r : '0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // table memories: one write port, registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[count_r[AW-1:0]] <= in_word.entry_time;
      off_mem[count_r[AW-1:0]]  <= in_word.entry_offset;
    end
    rd_time_r <= time_mem[mid_nxt[AW-1:0]];
    rd_off_r  <= off_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    eq_r         <= eq_nxt;
    q_r          <= q_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

FILE: test/tb_top.sv
// self-checking bench for sorted_time_table_seek_top: clear, append and seek words
// on a valid/ready input channel, results scored against a table predictor here
// depends on stts_pkg and the block's rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stts_pkg::*;

  localparam int TBL_DEPTH = TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP = 40;
  localparam logic [62:0] TIME_MAX = '1;
  localparam logic [63:0] QUERY_MIN = 64'h8000_0000_0000_0000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  sorted_time_table_seek_top #(.TABLE_DEPTH(TBL_DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  always #10 clk = ~clk;

  // predicted table contents
  logic [62:0] start_times [TBL_DEPTH];
  logic [63:0] chunk_offs [TBL_DEPTH];
  int unsigned stored_count = 0;
  logic [62:0] newest_time = '0;

  // what the stimulus expects the table to hold, used to aim the seeks
  logic [62:0] plan_times [$];
  logic [62:0] plan_last = '0;

  in_word_t  stim_words [$];
  out_word_t pending_results [$];
  int        words_planned = 0;
  int        words_accepted = 0;
  int        mismatch_count = 0;
  int        status_seen [8] = '{default: 0};
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      in_fire = 1'b0;

  function automatic out_word_t seek_predict(in_word_t w);
    out_word_t   r;
    int unsigned lo, hi, mid, idx;
    logic [63:0] q;
    r = '0;
    case (w.cmd)
      CMD_CLEAR: begin
        stored_count = 0;
        newest_time = '0;
        r.status = ST_CLEARED;
      end
      CMD_APPEND: begin
        if (stored_count >= TBL_DEPTH) begin
          r.status = ST_FULL;
        end else if (stored_count > 0 && w.entry_time < newest_time) begin
          r.status = ST_ORDER;
        end else begin
          start_times[stored_count] = w.entry_time;
          chunk_offs[stored_count] = w.entry_offset;
          stored_count++;
          newest_time = w.entry_time;
          r.status = ST_STORED;
        end
      end
      default: begin
        if (stored_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          q = w.query_time;
          idx = 0;
          if (!q[63]) begin
            // lower bound: first entry not below the seek time
            lo = 0;
            hi = stored_count;
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if ({1'b0, start_times[mid]} < q) lo = mid + 1;
              else hi = mid;
            end
            if (lo >= stored_count) idx = stored_count - 1;
            else if ({1'b0, start_times[lo]} == q) idx = lo;
            else idx = (lo == 0) ? 0 : lo - 1;
          end
          r.status = ST_OK;
          r.chunk_number = idx[NUM_W-1:0];
          r.chunk_offset = chunk_offs[idx];
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void add_clear();
    in_word_t w;
    w.cmd = CMD_CLEAR;
    w.entry_time = 63'(rand64());
    w.entry_offset = rand64();
    w.query_time = rand64();
    stim_words.push_back(w);
    words_planned++;
    plan_times.delete();
    plan_last = '0;
  endfunction

  function automatic void add_append(logic [62:0] t, logic [63:0] off);
    in_word_t w;
    w.cmd = CMD_APPEND;
    w.entry_time = t;
    w.entry_offset = off;
    w.query_time = rand64();
    stim_words.push_back(w);
    words_planned++;
    if (plan_times.size() < TBL_DEPTH && (plan_times.size() == 0 || t >= plan_last)) begin
      plan_times.push_back(t);
      plan_last = t;
    end
  endfunction

  function automatic void add_query(logic [1:0] code, logic [63:0] q);
    in_word_t w;
    w.cmd = code;
    w.entry_time = 63'(rand64());
    w.entry_offset = rand64();
    w.query_time = q;
    stim_words.push_back(w);
    words_planned++;
  endfunction

  function automatic logic [1:0] seek_code();
    return ($urandom_range(3) == 0) ? CMD_QUERY_ALT : CMD_QUERY;
  endfunction

  // next in-order time: duplicates, small steps, large steps, saturating at the top
  function automatic logic [62:0] next_time();
    logic [63:0] v, inc;
    int          k;
    v = rand64();
    if (plan_times.size() == 0) return v[62:0] >> $urandom_range(62);
    k = $urandom_range(9);
    if (k < 2) inc = '0;
    else if (k < 5) inc = 64'($urandom_range(1, 3));
    else if (k < 8) inc = 64'($urandom_range(1, 100000));
    else inc = v >> 24;
    v = {1'b0, plan_last} + inc;
    if (v[63]) v = {1'b0, TIME_MAX};
    return v[62:0];
  endfunction

  function automatic logic [62:0] older_time();
    logic [63:0] v;
    v = rand64();
    return v[62:0] % plan_last;
  endfunction

  function automatic logic [63:0] pick_query();
    logic [63:0] v;
    logic [62:0] t;
    int          n;
    n = plan_times.size();
    v = rand64();
    if (n == 0) return v;
    t = plan_times[$urandom_range(n - 1)];
    case ($urandom_range(7))
      0: v = {1'b0, t};
      1: v = {1'b0, t} - 1;
      2: v = {1'b0, t} + 1;
      3: v = {1'b0, v[62:0]};
      4: v = {1'b1, v[62:0]};
      5: v = $urandom_range(1) ? {1'b0, TIME_MAX} : {1'b0, plan_last} + 1;
      6: v = {1'b0, v[62:0]} % ({1'b0, plan_times[0]} + 1);
      default: ;
    endcase
    return v;
  endfunction

  function automatic void add_random_mix(int n);
    int first, r;
    logic [63:0] v;
    first = words_planned;
    while (words_planned - first < n) begin
      r = $urandom_range(99);
      v = rand64();
      if (r < 8) add_clear();
      else if (r < 14) add_append(v[62:0], rand64());
      else if (r < 18) add_query(seek_code(), v);
      else if (r < 25 && plan_last != 0) add_append(older_time(), rand64());
      else if (r < 60) add_append(next_time(), rand64());
      else add_query(seek_code(), pick_query());
    end
  endfunction

  task automatic drain_all();
    while (words_accepted != words_planned || pending_results.size() != 0)
      @(negedge clk);
  endtask

  // input driver: a new word only once the previous one has been taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (stim_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_word <= stim_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    out_word_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end else if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with none expected", 64'(out_word.status), '0);
        end else begin
          want = pending_results.pop_front();
          status_seen[want.status]++;
          if (out_word.status !== want.status)
            report_mismatch("status", out_word.status, want.status);
          if (out_word.chunk_number !== want.chunk_number)
            report_mismatch("chunk_number", out_word.chunk_number, want.chunk_number);
          if (out_word.chunk_offset !== want.chunk_offset)
            report_mismatch("chunk_offset", out_word.chunk_offset, want.chunk_offset);
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(seek_predict(in_word));
        words_accepted++;
      end
    end
  end

  initial begin
    int r;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, duplicates, order violations, edges of the search
    add_query(CMD_QUERY, '0);
    add_query(CMD_QUERY_ALT, '1);
    add_append('0, '1);
    add_append('0, 64'h0123_4567_89ab_cdef);
    add_append(63'd5, 64'hfedc_ba98_7654_3210);
    add_append(63'd3, rand64());
    add_append(TIME_MAX, '0);
    add_query(CMD_QUERY, '0);
    add_query(CMD_QUERY, '1);
    add_query(CMD_QUERY, QUERY_MIN);
    add_query(CMD_QUERY, {1'b0, TIME_MAX});
    add_query(CMD_QUERY, 64'd4);
    add_query(CMD_QUERY, 64'd5);
    add_query(CMD_QUERY_ALT, 64'd6);
    add_clear();
    add_query(CMD_QUERY, 64'd7);
    add_append(63'd100, rand64());
    add_query(CMD_QUERY, 64'd50);
    add_query(CMD_QUERY, 64'd200);
    add_append(63'd50, rand64());
    add_append(63'd100, rand64());
    add_query(CMD_QUERY_ALT, 64'd100);
    add_clear();
    add_append(63'd1, rand64());
    add_query(CMD_QUERY, 64'd1);

    // fill the table to the top with seeks mixed in, then push past full
    add_clear();
    while (plan_times.size() < TBL_DEPTH) begin
      r = $urandom_range(99);
      if (r < 6) add_query(seek_code(), pick_query());
      else if (r < 8 && plan_last != 0) add_append(older_time(), rand64());
      else add_append(next_time(), rand64());
    end
    repeat (4) add_append(next_time(), rand64());
    add_append('0, rand64());
    repeat (8) add_query(seek_code(), pick_query());
    add_clear();
    drain_all();

    send_idle_pct = 72;
    add_random_mix(40);
    drain_all();

    send_idle_pct = 0;
    recv_stall_pct = 72;
    add_random_mix(40);
    drain_all();

    send_idle_pct = 26;
    recv_stall_pct = 26;
    add_random_mix(40);
    drain_all();

    // let any stray result word show up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (40) @(negedge clk);

    $display("%0d words over four idle/stall phases, table filled to %0d entries once",
             words_accepted, TBL_DEPTH);
    $display("results: %0d seek ok, %0d stored, %0d full, %0d out of order, %0d empty, %0d cleared",
             status_seen[ST_OK], status_seen[ST_STORED], status_seen[ST_FULL],
             status_seen[ST_ORDER], status_seen[ST_EMPTY], status_seen[ST_CLEARED]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
